// ===== design/spectrum_bin_attack_release_smoother_macros.svh =====
// Assertion helpers for the spectrum smoother RTL.
// Every check samples on aclk and is off while aresetn is low.
`ifndef SPECTRUM_BIN_ATTACK_RELEASE_SMOOTHER_MACROS_SVH
`define SPECTRUM_BIN_ATTACK_RELEASE_SMOOTHER_MACROS_SVH

// Check a consequence in the same cycle as its cause.
`define SBS_ASSERT(label, ante, cons, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |-> (cons)) \
        else $error(msg);

// Check a consequence in the cycle after its cause.
`define SBS_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== design/sbs_pkg.sv =====
`timescale 1ns / 1ps

package sbs_pkg;

    // Store geometry
    localparam int NUM_BINS = 256;
    localparam int POS_W    = $clog2(NUM_BINS);
    localparam logic [POS_W-1:0] POS_LAST = POS_W'(NUM_BINS - 1);

    // Field widths
    localparam int DB_W    = 16;
    localparam int COEF_W  = 16;
    localparam int LEVEL_W = 16;

    // Smoothing product: unsigned coefficient times 17-bit signed difference
    localparam int PROD_W = 2 * (COEF_W + 1);
    localparam int STEP_W = PROD_W - COEF_W;
    localparam logic signed [PROD_W-1:0] ROUND_HALF = PROD_W'(32768);

    // Display divider: one quotient bit per stage
    localparam int DIV_STAGES = LEVEL_W;
    localparam logic [LEVEL_W-1:0] LEVEL_FULL = '1;

    // Queue between front and back
    localparam int QUEUE_DEPTH = 4;
    localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
    localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

    // Register port
    localparam int PADDR_W = 4;
    localparam int PDATA_W = 32;
    localparam logic [COEF_W-1:0]      RISE_RESET  = 16'd29491;
    localparam logic [COEF_W-1:0]      FALL_RESET  = 16'd5243;
    localparam logic signed [DB_W-1:0] FLOOR_RESET = -16'sd23040;

    typedef enum logic [1:0] {
        REG_RISE  = 2'd0,
        REG_FALL  = 2'd1,
        REG_FLOOR = 2'd2
    } reg_index_t;

    typedef struct packed {
        logic [COEF_W-1:0]      rise;
        logic [COEF_W-1:0]      fall;
        logic signed [DB_W-1:0] floor_level;
    } cfg_t;

    // One classified bin on its way to the back end
    typedef struct packed {
        logic signed [DB_W-1:0] sample;
        logic [POS_W-1:0]       pos;
        logic                   copy;
        logic                   last;
    } bin_item_t;

    // What travels alongside the divider
    typedef struct packed {
        logic signed [DB_W-1:0] smoothed;
        logic                   last;
        logic                   fixed;
        logic [LEVEL_W-1:0]     fixed_level;
    } lvl_tag_t;

endpackage

// ===== design/spectrum_bin_attack_release_smoother.sv =====
`timescale 1ns / 1ps
// Spectrum bin attack/release smoother.
// Input channel (s_*): one spectrum bin per transfer, dB in signed Q8.8, s_last_in on the
// final bin of a frame, s_restart to reseed the store starting with this bin.
// Result channel (m_*): one transfer per bin with the new smoothed dB value, a Q0.16
// display level between the floor and 0 dB, and m_last_out copied from s_last_in.
// Register port: rise coefficient at 0x0, fall coefficient at 0x4, floor level at 0x8,
// all 16 bits in the low half of the data word; write only while the block is idle.
// Path: a bin passes through the input queue, the store read, multiply and round path,
// the floor clamp and the divider (one quotient bit per stage), then the result register.
// Throughput: one bin per cycle while the back end is not stalled. A bin whose store entry
// is still being updated by one of the three previous bins waits for that write, so after
// the first frame a frame of fewer than four bins waits on writes from the frame before.
// Reset: the first frame after reset or restart is copied into the store; coefficients
// and floor return to 0.45, 0.08 and -90 dB. The store itself is not cleared.
// When m_ready is low with a result waiting, the whole back end holds; a four-entry queue
// keeps s_ready high until it fills.
module spectrum_bin_attack_release_smoother import sbs_pkg::*; (
    input  logic                   aclk,
    input  logic                   aresetn,
    input  logic                   psel,
    input  logic                   penable,
    input  logic                   pwrite,
    input  logic [PADDR_W-1:0]     paddr,
    input  logic [PDATA_W-1:0]     pwdata,
    output logic [PDATA_W-1:0]     prdata,
    output logic                   pready,
    input  logic                   s_valid,
    output logic                   s_ready,
    input  logic signed [DB_W-1:0] s_sample_db,
    input  logic                   s_last_in,
    input  logic                   s_restart,
    output logic                   m_valid,
    input  logic                   m_ready,
    output logic signed [DB_W-1:0] m_smoothed_db,
    output logic [LEVEL_W-1:0]     m_display_level,
    output logic                   m_last_out
);

    cfg_t       cfg_reg, cfg_next;
    logic [1:0] reg_idx;
    logic       cfg_write;
    logic       queue_full;
    logic       push;
    bin_item_t  push_item;
    logic       q_pop;
    logic       q_avail;
    bin_item_t  q_head;

    assign pready    = 1'b1;
    assign reg_idx   = paddr[PADDR_W-1:2];
    assign cfg_write = psel && penable && pwrite;

    // Decode register writes
    always_comb begin
        cfg_next = cfg_reg;
        if (cfg_write) begin
            case (reg_idx)
                REG_RISE:  cfg_next.rise        = pwdata[COEF_W-1:0];
                REG_FALL:  cfg_next.fall        = pwdata[COEF_W-1:0];
                REG_FLOOR: cfg_next.floor_level = pwdata[DB_W-1:0];
                default:   cfg_next = cfg_reg;
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.rise        <= RISE_RESET;
            cfg_reg.fall        <= FALL_RESET;
            cfg_reg.floor_level <= FLOOR_RESET;
        end else begin
            cfg_reg <= cfg_next;
        end
    end

    // Return register contents on reads
    always_comb begin
        case (reg_idx)
            REG_RISE:  prdata = {{(PDATA_W - COEF_W){1'b0}}, cfg_reg.rise};
            REG_FALL:  prdata = {{(PDATA_W - COEF_W){1'b0}}, cfg_reg.fall};
            REG_FLOOR: prdata = {{(PDATA_W - DB_W){1'b0}}, cfg_reg.floor_level};
            default:   prdata = '0;
        endcase
    end

    sbs_front u_front (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .s_valid     (s_valid),
        .s_ready     (s_ready),
        .s_sample_db (s_sample_db),
        .s_last_in   (s_last_in),
        .s_restart   (s_restart),
        .queue_full  (queue_full),
        .push        (push),
        .push_item   (push_item)
    );

    sbs_queue u_queue (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .push      (push),
        .push_item (push_item),
        .full      (queue_full),
        .pop       (q_pop),
        .avail     (q_avail),
        .head      (q_head)
    );

    sbs_back u_back (
        .aclk            (aclk),
        .aresetn         (aresetn),
        .cfg             (cfg_reg),
        .q_avail         (q_avail),
        .q_head          (q_head),
        .q_pop           (q_pop),
        .m_valid         (m_valid),
        .m_ready         (m_ready),
        .m_smoothed_db   (m_smoothed_db),
        .m_display_level (m_display_level),
        .m_last_out      (m_last_out)
    );

endmodule

// ===== design/sbs_ram.sv =====
`timescale 1ns / 1ps

module sbs_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 256
) (
    input  logic                     aclk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    // Write one entry, read one entry; a read at the write address sees old data
    always_ff @(posedge aclk) begin
        if (we) begin
            mem_reg[waddr] <= wdata;
        end
        if (re) begin
            rdata_reg <= mem_reg[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

// ===== design/sbs_queue.sv =====
`timescale 1ns / 1ps
`include "spectrum_bin_attack_release_smoother_macros.svh"

module sbs_queue import sbs_pkg::*; (
    input  logic      aclk,
    input  logic      aresetn,
    input  logic      push,
    input  bin_item_t push_item,
    output logic      full,
    input  logic      pop,
    output logic      avail,
    output bin_item_t head
);

    bin_item_t          slot_reg [QUEUE_DEPTH];
    logic [QPTR_W-1:0]  wr_ptr_reg, wr_ptr_next;
    logic [QPTR_W-1:0]  rd_ptr_reg, rd_ptr_next;
    logic [QCNT_W-1:0]  count_reg, count_next;

    assign full  = (count_reg == QCNT_W'(QUEUE_DEPTH));
    assign avail = (count_reg != '0);
    assign head  = slot_reg[rd_ptr_reg];

    // Advance pointers and fill count
    always_comb begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (push) begin
            wr_ptr_next = (wr_ptr_reg == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (pop) begin
            rd_ptr_next = (rd_ptr_reg == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        end
        case ({push, pop})
            2'b10:   count_next = count_reg + 1'b1;
            2'b01:   count_next = count_reg - 1'b1;
            default: count_next = count_reg;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    // Store the pushed item
    always_ff @(posedge aclk) begin
        if (push) begin
            slot_reg[wr_ptr_reg] <= push_item;
        end
    end

    `SBS_ASSERT(a_queue_no_overflow, full, !push, "push into a full queue")
    `SBS_ASSERT(a_queue_no_underflow, !avail, !pop, "pop from an empty queue")

endmodule

// ===== design/sbs_front.sv =====
`timescale 1ns / 1ps
`include "spectrum_bin_attack_release_smoother_macros.svh"

module sbs_front import sbs_pkg::*; (
    input  logic                   aclk,
    input  logic                   aresetn,
    input  logic                   s_valid,
    output logic                   s_ready,
    input  logic signed [DB_W-1:0] s_sample_db,
    input  logic                   s_last_in,
    input  logic                   s_restart,
    input  logic                   queue_full,
    output logic                   push,
    output bin_item_t              push_item
);

    logic             ready_reg, ready_next;
    logic [POS_W-1:0] pos_reg, pos_next;
    logic             cur_ready;
    logic [POS_W-1:0] cur_pos;

    assign s_ready = !queue_full;
    assign push    = s_valid && !queue_full;

    // Apply restart before classifying the bin
    always_comb begin
        cur_ready = s_restart ? 1'b0 : ready_reg;
        cur_pos   = s_restart ? '0 : pos_reg;
    end

    // Tag the bin with its store entry and whether it seeds the store
    always_comb begin
        push_item.sample = s_sample_db;
        push_item.pos    = cur_pos;
        push_item.copy   = !cur_ready;
        push_item.last   = s_last_in;
    end

    // Track frame position and seeded state
    always_comb begin
        ready_next = ready_reg;
        pos_next   = pos_reg;
        if (push) begin
            if (s_last_in) begin
                ready_next = 1'b1;
                pos_next   = '0;
            end else begin
                ready_next = cur_ready;
                pos_next   = (cur_pos == POS_LAST) ? '0 : cur_pos + 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            ready_reg <= 1'b0;
            pos_reg   <= '0;
        end else begin
            ready_reg <= ready_next;
            pos_reg   <= pos_next;
        end
    end

    `SBS_ASSERT_NEXT(a_last_closes_frame, push && s_last_in, ready_reg && (pos_reg == '0), "frame end did not rewind")

endmodule

// ===== design/sbs_div.sv =====
`timescale 1ns / 1ps

module sbs_div import sbs_pkg::*; (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               en,
    input  logic               in_valid,
    input  logic [DB_W-1:0]    in_rem,
    input  lvl_tag_t           in_tag,
    input  logic [DB_W-1:0]    divisor,
    output logic               out_valid,
    output lvl_tag_t           out_tag,
    output logic [LEVEL_W-1:0] out_quot
);

    logic               valid_reg [DIV_STAGES];
    logic [DB_W-1:0]    rem_reg   [DIV_STAGES];
    logic [LEVEL_W-1:0] quot_reg  [DIV_STAGES];
    lvl_tag_t           tag_reg   [DIV_STAGES];

    for (genvar k = 0; k < DIV_STAGES; k++) begin : g_stage
        logic               src_valid;
        logic [DB_W-1:0]    src_rem;
        logic [LEVEL_W-1:0] src_quot;
        lvl_tag_t           src_tag;
        logic [DB_W:0]      rem2;
        logic [DB_W:0]      rem_sub;
        logic               take;

        // Pick up the previous stage or the divider inputs
        if (k == 0) begin : g_first
            assign src_valid = in_valid;
            assign src_rem   = in_rem;
            assign src_quot  = '0;
            assign src_tag   = in_tag;
        end else begin : g_next
            assign src_valid = valid_reg[k-1];
            assign src_rem   = rem_reg[k-1];
            assign src_quot  = quot_reg[k-1];
            assign src_tag   = tag_reg[k-1];
        end

        // Develop one quotient bit: shift, trial subtract, restore
        assign rem2    = {src_rem, 1'b0};
        assign rem_sub = rem2 - {1'b0, divisor};
        assign take    = (rem2 >= {1'b0, divisor});

        always_ff @(posedge aclk) begin
            if (!aresetn) begin
                valid_reg[k] <= 1'b0;
            end else if (en) begin
                valid_reg[k] <= src_valid;
            end
        end

        always_ff @(posedge aclk) begin
            if (en) begin
                rem_reg[k]  <= take ? rem_sub[DB_W-1:0] : rem2[DB_W-1:0];
                quot_reg[k] <= {src_quot[LEVEL_W-2:0], take};
                tag_reg[k]  <= src_tag;
            end
        end
    end

    assign out_valid = valid_reg[DIV_STAGES-1];
    assign out_tag   = tag_reg[DIV_STAGES-1];
    assign out_quot  = quot_reg[DIV_STAGES-1];

endmodule

// ===== design/sbs_back.sv =====
`timescale 1ns / 1ps
`include "spectrum_bin_attack_release_smoother_macros.svh"

module sbs_back import sbs_pkg::*; (
    input  logic                   aclk,
    input  logic                   aresetn,
    input  cfg_t                   cfg,
    input  logic                   q_avail,
    input  bin_item_t              q_head,
    output logic                   q_pop,
    output logic                   m_valid,
    input  logic                   m_ready,
    output logic signed [DB_W-1:0] m_smoothed_db,
    output logic [LEVEL_W-1:0]     m_display_level,
    output logic                   m_last_out
);

    // Pipeline advance and issue control
    logic advance;
    logic hazard;
    logic issue;

    // Store port
    logic             ram_we;
    logic [POS_W-1:0] ram_waddr;
    logic [DB_W-1:0]  ram_wdata;
    logic [DB_W-1:0]  ram_rdata;

    // Stage 1: read data arrives, pick coefficient and difference
    logic                   p1_valid_reg;
    bin_item_t              p1_item_reg;
    logic signed [DB_W-1:0] p1_sample;
    logic signed [DB_W-1:0] p1_prev;
    logic signed [DB_W:0]   p1_diff;
    logic [COEF_W-1:0]      p1_coef;

    // Stage 2: multiply
    logic                   p2_valid_reg;
    bin_item_t              p2_item_reg;
    logic signed [DB_W-1:0] p2_prev_reg;
    logic signed [DB_W:0]   p2_diff_reg;
    logic [COEF_W-1:0]      p2_coef_reg;
    logic signed [PROD_W-1:0] p2_prod;

    // Stage 3: round, add, write back
    logic                     p3_valid_reg;
    bin_item_t                p3_item_reg;
    logic signed [DB_W-1:0]   p3_prev_reg;
    logic signed [PROD_W-1:0] p3_prod_reg;
    logic signed [PROD_W-1:0] p3_round;
    logic signed [STEP_W-1:0] p3_step;
    logic signed [STEP_W-1:0] p3_sum;
    logic signed [DB_W-1:0]   p3_result;

    // Stage 4: clamp to floor, set up the divide
    logic                   p4_valid_reg;
    logic signed [DB_W-1:0] p4_result_reg;
    logic                   p4_last_reg;
    logic signed [DB_W-1:0] p4_floor;
    logic signed [DB_W-1:0] p4_db;
    logic [DB_W:0]          p4_num_wide;
    logic [DB_W:0]          p4_den_wide;
    lvl_tag_t               p4_tag;

    // Divider and result register
    logic               div_valid;
    lvl_tag_t           div_tag;
    logic [LEVEL_W-1:0] div_quot;
    logic                   m_valid_reg;
    logic signed [DB_W-1:0] m_smoothed_reg;
    logic [LEVEL_W-1:0]     m_level_reg;
    logic                   m_last_reg;

    // Move everything one stage whenever the result register can take data
    assign advance = !m_valid_reg || m_ready;

    // Hold a smoothing bin while an earlier write to its entry is still in flight
    assign hazard = !q_head.copy &&
                    ((p1_valid_reg && (p1_item_reg.pos == q_head.pos)) ||
                     (p2_valid_reg && (p2_item_reg.pos == q_head.pos)) ||
                     (p3_valid_reg && (p3_item_reg.pos == q_head.pos)));
    assign issue   = q_avail && advance && !hazard;
    assign q_pop   = issue;

    sbs_ram #(
        .WIDTH (DB_W),
        .DEPTH (NUM_BINS)
    ) u_store (
        .aclk  (aclk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .re    (advance),
        .raddr (q_head.pos),
        .rdata (ram_rdata)
    );

    // Stage 1 compare and subtract
    always_comb begin
        p1_sample = p1_item_reg.sample;
        p1_prev   = ram_rdata;
        p1_diff   = {p1_sample[DB_W-1], p1_sample} - {p1_prev[DB_W-1], p1_prev};
        p1_coef   = (p1_sample > p1_prev) ? cfg.rise : cfg.fall;
    end

    // Stage 2 product
    assign p2_prod = $signed({1'b0, p2_coef_reg}) * p2_diff_reg;

    // Stage 3: round half up, floor, and step from the old value
    assign p3_round  = p3_prod_reg + ROUND_HALF;
    assign p3_step   = p3_round[PROD_W-1:COEF_W];
    assign p3_sum    = $signed({{(STEP_W - DB_W){p3_prev_reg[DB_W-1]}}, p3_prev_reg}) + p3_step;
    assign p3_result = p3_item_reg.copy ? p3_item_reg.sample : p3_sum[DB_W-1:0];

    assign ram_we    = p3_valid_reg && advance;
    assign ram_waddr = p3_item_reg.pos;
    assign ram_wdata = p3_result;

    // Stage 4: levels at or above 0 dB need no divide
    always_comb begin
        p4_floor    = cfg.floor_level;
        p4_db       = (p4_result_reg < p4_floor) ? p4_floor : p4_result_reg;
        p4_num_wide = {p4_db[DB_W-1], p4_db} - {p4_floor[DB_W-1], p4_floor};
        p4_den_wide = {(DB_W + 1){1'b0}} - {p4_floor[DB_W-1], p4_floor};
        p4_tag.smoothed    = p4_result_reg;
        p4_tag.last        = p4_last_reg;
        p4_tag.fixed       = !p4_db[DB_W-1];
        p4_tag.fixed_level = ((p4_db != '0) || p4_floor[DB_W-1]) ? LEVEL_FULL : '0;
    end

    sbs_div u_div (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .en        (advance),
        .in_valid  (p4_valid_reg),
        .in_rem    (p4_num_wide[DB_W-1:0]),
        .in_tag    (p4_tag),
        .divisor   (p4_den_wide[DB_W-1:0]),
        .out_valid (div_valid),
        .out_tag   (div_tag),
        .out_quot  (div_quot)
    );

    // Stage valids
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            p1_valid_reg <= 1'b0;
            p2_valid_reg <= 1'b0;
            p3_valid_reg <= 1'b0;
            p4_valid_reg <= 1'b0;
            m_valid_reg  <= 1'b0;
        end else if (advance) begin
            p1_valid_reg <= issue;
            p2_valid_reg <= p1_valid_reg;
            p3_valid_reg <= p2_valid_reg;
            p4_valid_reg <= p3_valid_reg;
            m_valid_reg  <= div_valid;
        end
    end

    // Stage payloads
    always_ff @(posedge aclk) begin
        if (advance) begin
            p1_item_reg    <= q_head;
            p2_item_reg    <= p1_item_reg;
            p2_prev_reg    <= p1_prev;
            p2_diff_reg    <= p1_diff;
            p2_coef_reg    <= p1_coef;
            p3_item_reg    <= p2_item_reg;
            p3_prev_reg    <= p2_prev_reg;
            p3_prod_reg    <= p2_prod;
            p4_result_reg  <= p3_result;
            p4_last_reg    <= p3_item_reg.last;
            m_smoothed_reg <= div_tag.smoothed;
            m_level_reg    <= div_tag.fixed ? div_tag.fixed_level : div_quot;
            m_last_reg     <= div_tag.last;
        end
    end

    assign m_valid         = m_valid_reg;
    assign m_smoothed_db   = m_smoothed_reg;
    assign m_display_level = m_level_reg;
    assign m_last_out      = m_last_reg;

    `SBS_ASSERT(a_no_write_while_stalled, m_valid_reg && !m_ready, !ram_we, "store written during stall")
    `SBS_ASSERT(a_no_stale_read, issue && !q_head.copy && ram_we, ram_waddr != q_head.pos, "read races write")

endmodule

// ===== tb/spectrum_bin_attack_release_smoother_tb.sv =====
`timescale 1ns / 1ps

module spectrum_bin_attack_release_smoother_tb;
    import sbs_pkg::*;

    localparam int CYCLE_LIMIT  = 400000;
    localparam int DRAIN_CYCLES = 40;
    localparam int SETTLE_CYCLES = 8;
    localparam int PHASE_BINS   = 145;
    localparam int MAX_PRINTED  = 40;

    typedef struct packed {
        logic signed [DB_W-1:0] smoothed;
        logic [LEVEL_W-1:0]     level;
        logic                   last;
    } bin_result_t;

    logic                   aclk          = 1'b0;
    logic                   aresetn       = 1'b0;
    logic                   psel          = 1'b0;
    logic                   penable       = 1'b0;
    logic                   pwrite        = 1'b0;
    logic [PADDR_W-1:0]     paddr         = '0;
    logic [PDATA_W-1:0]     pwdata        = '0;
    logic [PDATA_W-1:0]     prdata;
    logic                   pready;
    logic                   s_valid       = 1'b0;
    logic                   s_ready;
    logic signed [DB_W-1:0] s_sample_db   = '0;
    logic                   s_last_in     = 1'b0;
    logic                   s_restart     = 1'b0;
    logic                   m_valid;
    logic                   m_ready       = 1'b0;
    logic signed [DB_W-1:0] m_smoothed_db;
    logic [LEVEL_W-1:0]     m_display_level;
    logic                   m_last_out;

    // Smoother state as the block should hold it
    logic [COEF_W-1:0]      rise_coef;
    logic [COEF_W-1:0]      fall_coef;
    logic signed [DB_W-1:0] floor_level;
    logic signed [DB_W-1:0] bin_level [NUM_BINS];
    logic                   bin_written [NUM_BINS];
    logic                   frame_seeded;
    logic [POS_W-1:0]       bin_pos;

    bin_result_t expected_bins[$];
    int err_count      = 0;
    int cycle_count    = 0;
    int send_idle_pct  = 0;
    int recv_stall_pct = 0;

    spectrum_bin_attack_release_smoother dut (
        .aclk            (aclk),
        .aresetn         (aresetn),
        .psel            (psel),
        .penable         (penable),
        .pwrite          (pwrite),
        .paddr           (paddr),
        .pwdata          (pwdata),
        .prdata          (prdata),
        .pready          (pready),
        .s_valid         (s_valid),
        .s_ready         (s_ready),
        .s_sample_db     (s_sample_db),
        .s_last_in       (s_last_in),
        .s_restart       (s_restart),
        .m_valid         (m_valid),
        .m_ready         (m_ready),
        .m_smoothed_db   (m_smoothed_db),
        .m_display_level (m_display_level),
        .m_last_out      (m_last_out)
    );

    always #4 aclk = ~aclk;

    // Map a smoothed level onto the display scale
    function automatic logic [LEVEL_W-1:0] display_level_of(input logic signed [DB_W-1:0] v);
        int     db;
        longint t;
        db = (v < floor_level) ? int'(floor_level) : int'(v);
        if (db > 0)
            return LEVEL_FULL;
        if (floor_level >= 0)
            return '0;
        t = (longint'(db - int'(floor_level)) * 65536) / longint'(-int'(floor_level));
        if (t > 65535)
            t = 65535;
        if (t < 0)
            t = 0;
        return LEVEL_W'(t);
    endfunction

    // Advance the bin store by one bin and return what the block should produce
    function automatic bin_result_t predict_bin(input logic signed [DB_W-1:0] db,
                                                input logic last, input logic rst);
        bin_result_t       r;
        int                prev;
        int                next;
        longint            step;
        logic [COEF_W-1:0] coef;
        if (rst) begin
            frame_seeded = 1'b0;
            bin_pos      = '0;
        end
        if (!frame_seeded) begin
            next = int'(db);
        end else begin
            prev = int'(bin_level[bin_pos]);
            coef = (int'(db) > prev) ? rise_coef : fall_coef;
            step = (longint'(coef) * longint'(int'(db) - prev) + 32768) >>> 16;
            next = prev + int'(step);
            if (next > 32767)
                next = 32767;
            if (next < -32768)
                next = -32768;
        end
        bin_level[bin_pos]   = DB_W'(next);
        bin_written[bin_pos] = 1'b1;
        if (last) begin
            frame_seeded = 1'b1;
            bin_pos      = '0;
        end else begin
            bin_pos = bin_pos + 1'b1;
        end
        r.smoothed = DB_W'(next);
        r.level    = display_level_of(r.smoothed);
        r.last     = last;
        return r;
    endfunction

    function automatic logic signed [DB_W-1:0] pick_db();
        case ($urandom_range(9))
            0: return $urandom_range(1) ? 16'sh7FFF : 16'sh8000;
            // around 0 dB, where the display saturates
            1, 2: return DB_W'($urandom_range(2048)) - 16'sd1024;
            // around the display floor
            3, 4: return floor_level + DB_W'($urandom_range(2048)) - 16'sd1024;
            default: return DB_W'($urandom);
        endcase
    endfunction

    task automatic report_mismatch(input string what, input longint got, input longint want);
        if (err_count < MAX_PRINTED)
            $display("mismatch %s at %0t: got %0d expected %0d", what, $realtime, got, want);
        err_count++;
    endtask

    // Send one bin and hold it until the transfer completes
    task automatic send_bin(input logic signed [DB_W-1:0] db, input logic last,
                            input logic rst);
        logic             seeded;
        logic [POS_W-1:0] pos;
        logic             last_eff;
        seeded   = rst ? 1'b0 : frame_seeded;
        pos      = rst ? '0 : bin_pos;
        last_eff = last;
        // end the frame early where the next bin has no stored level yet
        if (seeded && !bin_written[POS_W'(pos + 1'b1)])
            last_eff = 1'b1;
        while ($urandom_range(99) < send_idle_pct) begin
            s_valid <= 1'b0;
            @(posedge aclk);
        end
        expected_bins.push_back(predict_bin(db, last_eff, rst));
        s_valid     <= 1'b1;
        s_sample_db <= db;
        s_last_in   <= last_eff;
        s_restart   <= rst;
        @(posedge aclk);
        while (!s_ready)
            @(posedge aclk);
    endtask

    task automatic send_frame(input int len, input logic restart_first);
        for (int i = 0; i < len; i++)
            send_bin(pick_db(), i == len - 1, restart_first && i == 0);
    endtask

    // Drop valid and wait until every result has come back
    task automatic wait_idle();
        s_valid <= 1'b0;
        while (expected_bins.size() != 0)
            @(posedge aclk);
        repeat (SETTLE_CYCLES) @(posedge aclk);
    endtask

    // Write one register, then read it back
    task automatic cfg_write(input reg_index_t idx, input logic [PDATA_W-1:0] val);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {idx, 2'b00};
        pwdata  <= val;
        @(posedge aclk);
        penable <= 1'b1;
        @(posedge aclk);
        while (!pready)
            @(posedge aclk);
        case (idx)
            REG_RISE:  rise_coef   = val[COEF_W-1:0];
            REG_FALL:  fall_coef   = val[COEF_W-1:0];
            REG_FLOOR: floor_level = val[DB_W-1:0];
            default: ;
        endcase
        penable <= 1'b0;
        pwrite  <= 1'b0;
        @(posedge aclk);
        penable <= 1'b1;
        @(posedge aclk);
        while (!pready)
            @(posedge aclk);
        if (prdata[15:0] !== val[15:0])
            report_mismatch("register readback", prdata[15:0], val[15:0]);
        psel    <= 1'b0;
        penable <= 1'b0;
        @(posedge aclk);
    endtask

    task automatic apply_config(input logic [COEF_W-1:0] rise, input logic [COEF_W-1:0] fall,
                                input logic signed [DB_W-1:0] fl);
        wait_idle();
        cfg_write(REG_RISE, PDATA_W'(rise));
        cfg_write(REG_FALL, PDATA_W'(fall));
        cfg_write(REG_FLOOR, PDATA_W'(fl));
    endtask

    // Seed frame and first smoothed frame with the reset coefficients and floor
    task automatic test_reset_values();
        logic signed [DB_W-1:0] seed [8];
        logic signed [DB_W-1:0] pull [8];
        seed = '{16'sh7FFF, 16'sh8000, 16'sd0, -16'sd23040, -16'sd23041, 16'sd256,
                 -16'sd1, -16'sd11520};
        pull = '{16'sh8000, 16'sh7FFF, 16'sd0, 16'sd0, -16'sd23040, -16'sd256,
                 16'sd1, 16'sh7FFF};
        for (int i = 0; i < 8; i++)
            send_bin(seed[i], i == 7, 1'b0);
        for (int i = 0; i < 8; i++)
            send_bin(pull[i], i == 7, 1'b0);
    endtask

    // Restart on a single-bin frame, and restart in the middle of a frame
    task automatic test_restart_cases();
        send_bin(16'sd1234, 1'b1, 1'b1);
        send_bin(-16'sd5000, 1'b1, 1'b0);
        send_bin(16'sd0, 1'b0, 1'b0);
        send_bin(16'sd100, 1'b0, 1'b0);
        send_bin(16'sd200, 1'b0, 1'b0);
        send_bin(-16'sd3000, 1'b0, 1'b1);
        send_bin(16'sd3000, 1'b0, 1'b0);
        send_bin(-16'sd100, 1'b1, 1'b0);
        send_frame(3, 1'b0);
    endtask

    // Seed frame longer than the store, so the bin position wraps
    task automatic test_long_frame();
        send_frame(NUM_BINS + 4, 1'b1);
        send_frame(6, 1'b0);
    endtask

    task automatic test_register_extremes();
        apply_config(16'hFFFF, 16'h0000, 16'sh8000);
        send_frame(6, 1'b1);
        send_frame(6, 1'b0);
        send_frame(6, 1'b0);
        apply_config(16'h0000, 16'hFFFF, -16'sd256);
        send_frame(6, 1'b0);
        send_frame(6, 1'b0);
        send_frame(6, 1'b1);
        send_frame(6, 1'b0);
    endtask

    // Frames of random length and content under each idling pattern
    task automatic test_random_traffic();
        int   sent;
        int   len;
        logic start_rst;
        logic rst;
        for (int mode = 0; mode < 4; mode++) begin
            case (mode)
                0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
                1: begin send_idle_pct = 83; recv_stall_pct = 0;  end
                2: begin send_idle_pct = 0;  recv_stall_pct = 83; end
                default: begin send_idle_pct = 32; recv_stall_pct = 32; end
            endcase
            for (int sub = 0; sub < 2; sub++) begin
                apply_config(COEF_W'($urandom), COEF_W'($urandom),
                             DB_W'(-(256 + int'($urandom_range(32512)))));
                sent = 0;
                while (sent < PHASE_BINS) begin
                    len = ($urandom_range(19) == 0) ? $urandom_range(80, 17)
                                                   : $urandom_range(16, 1);
                    start_rst = ($urandom_range(19) == 0);
                    for (int i = 0; i < len; i++) begin
                        // occasional restart in the middle of a frame
                        rst = (i == 0 && start_rst) || ($urandom_range(49) == 0);
                        send_bin(pick_db(), i == len - 1, rst);
                    end
                    sent += len;
                end
            end
        end
        send_idle_pct  = 0;
        recv_stall_pct = 0;
    endtask

    // Randomize result backpressure
    always @(posedge aclk)
        m_ready <= ($urandom_range(99) >= recv_stall_pct);

    // Compare each result transfer with the oldest expected bin
    always @(posedge aclk) begin
        bin_result_t want;
        if (aresetn && m_valid && m_ready) begin
            if (expected_bins.size() == 0) begin
                report_mismatch("result with none expected", m_smoothed_db, 0);
            end else begin
                want = expected_bins.pop_front();
                if (m_smoothed_db !== want.smoothed)
                    report_mismatch("smoothed_db", m_smoothed_db, want.smoothed);
                if (m_display_level !== want.level)
                    report_mismatch("display_level", m_display_level, want.level);
                if (m_last_out !== want.last)
                    report_mismatch("last_out", m_last_out, want.last);
            end
        end
    end

    // Stop a hung run
    always @(posedge aclk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("TB_ERROR");
            $finish;
        end
    end

    initial begin
        rise_coef    = RISE_RESET;
        fall_coef    = FALL_RESET;
        floor_level  = FLOOR_RESET;
        frame_seeded = 1'b0;
        bin_pos      = '0;
        for (int i = 0; i < NUM_BINS; i++) begin
            bin_level[i]   = '0;
            bin_written[i] = 1'b0;
        end
        repeat (9) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        test_reset_values();
        test_restart_cases();
        test_long_frame();
        test_register_extremes();
        test_random_traffic();

        s_valid <= 1'b0;
        while (expected_bins.size() != 0)
            @(posedge aclk);
        repeat (DRAIN_CYCLES) @(posedge aclk);
        if (err_count == 0)
            $display("TB_OK");
        else
            $display("TB_ERROR");
        $finish;
    end

endmodule
